[rtl/qpht_pkg.sv]
// qpht_pkg: types, codes and default sizes for the quadratic-probe hash table.
// No dependencies; imported only by the top level, quadratic_probe_hash_table.
package qpht_pkg;

  localparam int unsigned KEY_W          = 31;
  localparam int unsigned SLOT_W         = 10;
  localparam int unsigned PROBE_W        = 6;
  localparam int unsigned TABLE_SIZE_DEF = 1021;
  localparam int unsigned MAX_PROBES_DEF = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_LIMIT     = 2'd2,
    ST_BAD_KEY   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_MUL,
    S_SUB,
    S_HOME,
    S_READ,
    S_EVAL,
    S_SQ,
    S_ODD
  } state_e;

  typedef struct packed {
    action_e            action;
    logic [KEY_W-1:0]   key;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [PROBE_W-1:0] probes;
  } rsp_t;

endpackage

[rtl/qpht_modadd.sv]
// qpht_modadd: shared modular adder, (a + b + cin) mod MODULUS with a, b below MODULUS.
// Uses no package items; serves every probe index step.
module qpht_modadd #(
  parameter int unsigned MODULUS = 1021,
  parameter int unsigned IW      = 10
) (
  input  logic [IW-1:0] a_i,
  input  logic [IW-1:0] b_i,
  input  logic          cin_i,
  output logic [IW-1:0] sum_o
);

  localparam logic [IW:0] ModW = (IW+1)'(MODULUS);

  logic [IW:0] raw;

  assign raw   = {1'b0, a_i} + {1'b0, b_i} + {{IW{1'b0}}, cin_i};
  assign sum_o = (raw >= ModW) ? IW'(raw - ModW) : IW'(raw);

endmodule

[rtl/qpht_mem.sv]
// qpht_mem: key store, one write port and one registered read port.
// Uses no package items; instantiated by the top level.
module qpht_mem #(
  parameter int unsigned DEPTH = 1021,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 31
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/quadratic_probe_hash_table.sv]
// quadratic_probe_hash_table: open-addressing key table with quadratic probing.
// Depends on qpht_pkg, qpht_modadd and qpht_mem.
//
//   channel   ports                 transfer condition
//   request   start_i, req_i        start_i high while busy_o low
//   result    done_o, rsp_o         done_o high, one cycle per result
//
// Insert/search/delete: S_MUL, S_SUB, S_HOME reach the home slot (reciprocal
// multiply, subtract, fold); a probe that moves on passes S_READ, S_EVAL, S_SQ,
// S_ODD (memory read, compare, two step updates), the deciding one S_READ and
// S_EVAL; the result strobes the cycle after. Zero key: result next cycle. Clear:
// one write per slot, then the result. After reset the sweep runs with busy_o high.
// Results cannot be stalled; busy_o is low in the cycle a result is shown.
module quadratic_probe_hash_table
  import qpht_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int unsigned MAX_PROBES = MAX_PROBES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned IW = $clog2(TABLE_SIZE);
  localparam int unsigned PW = $clog2(MAX_PROBES + 1);
  localparam logic [IW-1:0] LastIdx = IW'(TABLE_SIZE - 1);
  localparam logic [IW-1:0] Sq0     = IW'(1);
  localparam logic [IW-1:0] Odd0    = IW'(3 % TABLE_SIZE);
  localparam logic [PW-1:0] MaxPr   = PW'(MAX_PROBES);
  localparam logic [IW:0]   ModW1   = (IW+1)'(TABLE_SIZE);
  // floor(2^KEY_W / TABLE_SIZE): quotient estimate is exact or one low
  localparam logic [KEY_W-1:0] Recip = KEY_W'((64'd1 << KEY_W) / TABLE_SIZE);

  state_e              state_q, state_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [IW-1:0]       sq_q, sq_d;
  logic [IW-1:0]       odd_q, odd_d;
  logic [PW-1:0]       probes_q, probes_d;
  logic [IW:0]         quot_q, quot_d;
  logic [IW:0]         rem_q, rem_d;
  logic                report_q, report_d;
  logic                done_q, done_d;
  rsp_t                rsp_q, rsp_d;
  action_e             action_q, action_d;
  logic [KEY_W-1:0]    key_q, key_d;

  logic [IW-1:0]       ua, ub, usum;
  logic                ucin;
  logic                mem_we, mem_re;
  logic [KEY_W-1:0]    mem_wdata, mem_rdata;
  logic [PW-1:0]       probes_n;
  logic [2*KEY_W-1:0]  prod;
  logic [IW:0]         rem_n;

  qpht_modadd #(
    .MODULUS(TABLE_SIZE),
    .IW     (IW)
  ) u_modadd (
    .a_i  (ua),
    .b_i  (ub),
    .cin_i(ucin),
    .sum_o(usum)
  );

  qpht_mem #(
    .DEPTH(TABLE_SIZE),
    .AW   (IW),
    .DW   (KEY_W)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(idx_q),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(idx_q),
    .rdata_o(mem_rdata)
  );

  // home slot: key - q*M lies in [0, 2M), so low IW+1 bits suffice
  assign prod  = {{KEY_W{1'b0}}, key_q} * {{KEY_W{1'b0}}, Recip};
  assign rem_n = key_q[IW:0] - (IW+1)'(quot_q * ModW1);

  // operand select for the shared adder
  always_comb begin
    ua   = '0;
    ub   = '0;
    ucin = 1'b0;
    unique case (state_q)
      S_EVAL: begin
        ua = idx_q;
        ub = sq_q;
      end
      S_SQ: begin
        ua = sq_q;
        ub = odd_q;
      end
      S_ODD: begin
        ua   = odd_q;
        ub   = IW'(1);
        ucin = 1'b1;
      end
      default: begin
        ua = '0;
      end
    endcase
  end

  assign probes_n = probes_q + PW'(1);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    sq_d      = sq_q;
    odd_d     = odd_q;
    probes_d  = probes_q;
    quot_d    = quot_q;
    rem_d     = rem_q;
    report_d  = report_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    action_d  = action_q;
    key_d     = key_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          action_d = req_i.action;
          key_d    = req_i.key;
          if (req_i.action == ACT_CLEAR) begin
            state_d  = S_CLEAR;
            idx_d    = '0;
            report_d = 1'b1;
          end else if (req_i.key == '0) begin
            done_d = 1'b1;
            rsp_d  = '{status: ST_BAD_KEY, slot: '0, probes: '0};
          end else begin
            state_d  = S_MUL;
            idx_d    = '0;
            sq_d     = Sq0;
            odd_d    = Odd0;
            probes_d = '0;
          end
        end
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        if (idx_q == LastIdx) begin
          state_d  = S_IDLE;
          report_d = 1'b0;
          if (report_q) begin
            done_d = 1'b1;
            rsp_d  = '{status: ST_OK, slot: '0, probes: '0};
          end
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_MUL: begin
        quot_d  = prod[KEY_W+IW:KEY_W];
        state_d = S_SUB;
      end
      S_SUB: begin
        rem_d   = rem_n;
        state_d = S_HOME;
      end
      S_HOME: begin
        idx_d   = (rem_q >= ModW1) ? IW'(rem_q - ModW1) : IW'(rem_q);
        state_d = S_READ;
      end
      S_READ: begin
        mem_re  = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (mem_rdata == '0) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          if (action_q == ACT_INSERT) begin
            mem_we    = 1'b1;
            mem_wdata = key_q;
            rsp_d = '{status: ST_OK, slot: SLOT_W'(idx_q), probes: PROBE_W'(probes_q)};
          end else begin
            rsp_d = '{status: ST_NOT_FOUND, slot: '0, probes: PROBE_W'(probes_q)};
          end
        end else if (action_q != ACT_INSERT && mem_rdata == key_q) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          mem_we  = (action_q == ACT_DELETE);
          rsp_d   = '{status: ST_OK, slot: SLOT_W'(idx_q), probes: PROBE_W'(probes_n)};
        end else if (probes_n == MaxPr) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          rsp_d   = '{status: ST_LIMIT, slot: '0, probes: PROBE_W'(probes_n)};
        end else begin
          probes_d = probes_n;
          idx_d    = usum;
          state_d  = S_SQ;
        end
      end
      S_SQ: begin
        sq_d    = usum;
        state_d = S_ODD;
      end
      S_ODD: begin
        odd_d   = usum;
        state_d = S_READ;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      idx_q    <= '0;
      report_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      report_q <= report_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q     <= sq_d;
    odd_q    <= odd_d;
    probes_q <= probes_d;
    quot_q   <= quot_d;
    rem_q    <= rem_d;
    rsp_q    <= rsp_d;
    action_q <= action_d;
    key_q    <= key_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == S_IDLE)
    else $error("result shown while sequencer not idle");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted request neither started nor answered");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL |-> probes_q < MaxPr)
    else $error("probe count past limit");

  a_limit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_LIMIT) |-> rsp_o.probes == PROBE_W'(MAX_PROBES))
    else $error("probe limit result with wrong count");

endmodule
